### rtl/core/twt_pkg.sv
package twt_pkg;

   localparam int CAPACITY = 32;
   localparam int ID_BITS = 8;
   localparam int TIME_BITS = 32;
   localparam int CNT_BITS = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_ERASE    = 2'd1,
      CMD_TAKE     = 2'd2,
      CMD_CONTAINS = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_DUP  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_KILL,
      OP_COMPACT
   } op_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      op_type                 op;
      logic [ID_BITS-1:0]     id;
      logic [TIME_BITS-1:0]   time_value;
   } twt_ctrl_type;

   // what the chain shows back to the sequencer
   typedef struct packed {
      logic                   head_valid;
      logic [ID_BITS-1:0]     head_id;
      logic [TIME_BITS-1:0]   head_time;
      logic                   full;
      logic                   hit;
   } twt_chain_type;

endpackage

### rtl/core/twt_cell.sv
module twt_cell import twt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  twt_ctrl_type         ctrl,
   input  logic                 left_valid,
   input  logic                 left_ins,
   input  logic [ID_BITS-1:0]   left_id,
   input  logic [TIME_BITS-1:0] left_time,
   input  logic                 right_valid,
   input  logic [ID_BITS-1:0]   right_id,
   input  logic [TIME_BITS-1:0] right_time,
   output logic                 valid,
   output logic [ID_BITS-1:0]   id,
   output logic [TIME_BITS-1:0] time_value,
   output logic                 ins,
   output logic                 match
);

   logic                 valid_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 valid_in;
   logic [ID_BITS-1:0]   id_in;
   logic [TIME_BITS-1:0] time_in;

   assign match = valid_ff && (id_ff == ctrl.id);

   // new key sorts ahead of this cell (by time, then by smaller id)
   assign ins = !valid_ff || (ctrl.time_value < time_ff) ||
                ((ctrl.time_value == time_ff) && (ctrl.id < id_ff));

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      time_in  = time_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (left_ins) begin
               valid_in = left_valid;
               id_in    = left_id;
               time_in  = left_time;
            end else if (ins) begin
               valid_in = 1'b1;
               id_in    = ctrl.id;
               time_in  = ctrl.time_value;
            end
         end
         OP_KILL: begin
            if (match) begin
               valid_in = 1'b0;
            end
         end
         OP_COMPACT: begin
            // the single hole moves one cell towards the tail
            if (!valid_ff && right_valid) begin
               valid_in = 1'b1;
               id_in    = right_id;
               time_in  = right_time;
            end else if (valid_ff && !left_valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff   <= id_in;
      time_ff <= time_in;
   end

   assign valid      = valid_ff;
   assign id         = id_ff;
   assign time_value = time_ff;

endmodule

### rtl/core/twt_ctrl.sv
module twt_ctrl import twt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [ID_BITS-1:0]   req_task_id,
   input  logic [TIME_BITS-1:0] req_time_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [ID_BITS-1:0]   rsp_taken_id,
   output logic                 rsp_not_empty,
   output logic [TIME_BITS-1:0] rsp_earliest_time,
   input  twt_chain_type        chain,
   output twt_ctrl_type         ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_ACT,
      S_COMPACT,
      S_FINISH
   } state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 hit_ff;
   status_type           status_ff;
   logic [ID_BITS-1:0]   taken_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [ID_BITS-1:0]   rsp_taken_ff;
   logic                 rsp_not_empty_ff;
   logic [TIME_BITS-1:0] rsp_earliest_ff;
   logic                 due;

   assign due = chain.head_valid && (time_ff >= chain.head_time);

   always_comb begin
      ctrl.op         = OP_HOLD;
      ctrl.id         = id_ff;
      ctrl.time_value = time_ff;
      case (state_ff)
         S_ACT: begin
            case (cmd_ff)
               CMD_ADD: begin
                  if (!hit_ff && !chain.full) begin
                     ctrl.op = OP_INSERT;
                  end
               end
               CMD_ERASE: begin
                  if (hit_ff) begin
                     ctrl.op = OP_KILL;
                  end
               end
               CMD_TAKE: begin
                  ctrl.id = chain.head_id;
                  if (due) begin
                     ctrl.op = OP_KILL;
                  end
               end
               default: begin
               end
            endcase
         end
         S_COMPACT: begin
            ctrl.op = OP_COMPACT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= cmd_type'(req_command);
                  id_ff    <= req_task_id;
                  time_ff  <= req_time_value;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               hit_ff   <= chain.hit;
               state_ff <= S_ACT;
            end
            S_ACT: begin
               cnt_ff <= '0;
               case (cmd_ff)
                  CMD_ADD: begin
                     taken_ff <= '0;
                     state_ff <= S_FINISH;
                     if (hit_ff) begin
                        status_ff <= ST_DUP;
                     end else if (chain.full) begin
                        status_ff <= ST_FULL;
                     end else begin
                        status_ff <= ST_OK;
                     end
                  end
                  CMD_ERASE: begin
                     taken_ff  <= '0;
                     status_ff <= hit_ff ? ST_OK : ST_NONE;
                     state_ff  <= hit_ff ? S_COMPACT : S_FINISH;
                  end
                  CMD_TAKE: begin
                     if (due) begin
                        status_ff <= ST_OK;
                        taken_ff  <= chain.head_id;
                        state_ff  <= S_COMPACT;
                     end else begin
                        status_ff <= ST_NONE;
                        taken_ff  <= '0;
                        state_ff  <= S_FINISH;
                     end
                  end
                  default: begin
                     taken_ff  <= '0;
                     state_ff  <= S_FINISH;
                     status_ff <= hit_ff ? ST_OK : ST_NONE;
                  end
               endcase
            end
            S_COMPACT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(CAPACITY - 2)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= status_ff;
                  rsp_taken_ff     <= taken_ff;
                  rsp_not_empty_ff <= chain.head_valid;
                  rsp_earliest_ff  <= chain.head_valid ? chain.head_time : '0;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_taken_id      = rsp_taken_ff;
   assign rsp_not_empty     = rsp_not_empty_ff;
   assign rsp_earliest_time = rsp_earliest_ff;

endmodule

### rtl/core/timeout_ordered_wait_table.sv
// sequencing: look, act and finish states for add and contains, and for erase
//   or take that removes nothing; a compact state between act and finish when
//   an entry is removed, as the hole walks one cell per cycle down the chain
// requests: one at a time; the next is taken in idle, which finish enters only
//   once the previous response is no longer held
// reset: synchronous, clears every cell valid bit and the sequencer; empty table
module timeout_ordered_wait_table import twt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [ID_BITS-1:0]   req_task_id,
   input  logic [TIME_BITS-1:0] req_time_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [ID_BITS-1:0]   rsp_taken_id,
   output logic                 rsp_not_empty,
   output logic [TIME_BITS-1:0] rsp_earliest_time
);

   twt_ctrl_type         ctrl;
   twt_chain_type        chain;
   logic                 cell_valid [CAPACITY];
   logic [ID_BITS-1:0]   cell_id    [CAPACITY];
   logic [TIME_BITS-1:0] cell_time  [CAPACITY];
   logic                 cell_ins   [CAPACITY];
   logic [CAPACITY-1:0]  match_vec;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                 lv;
         logic                 li;
         logic [ID_BITS-1:0]   lid;
         logic [TIME_BITS-1:0] lt;
         logic                 rv;
         logic [ID_BITS-1:0]   rid;
         logic [TIME_BITS-1:0] rt;

         if (i == 0) begin : g_first
            assign lv  = 1'b1;
            assign li  = 1'b0;
            assign lid = '0;
            assign lt  = '0;
         end else begin : g_mid_left
            assign lv  = cell_valid[i-1];
            assign li  = cell_ins[i-1];
            assign lid = cell_id[i-1];
            assign lt  = cell_time[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign rv  = 1'b0;
            assign rid = '0;
            assign rt  = '0;
         end else begin : g_mid_right
            assign rv  = cell_valid[i+1];
            assign rid = cell_id[i+1];
            assign rt  = cell_time[i+1];
         end

         twt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_valid  (lv),
            .left_ins    (li),
            .left_id     (lid),
            .left_time   (lt),
            .right_valid (rv),
            .right_id    (rid),
            .right_time  (rt),
            .valid       (cell_valid[i]),
            .id          (cell_id[i]),
            .time_value  (cell_time[i]),
            .ins         (cell_ins[i]),
            .match       (match_vec[i])
         );
      end
   endgenerate

   assign chain.head_valid = cell_valid[0];
   assign chain.head_id    = cell_id[0];
   assign chain.head_time  = cell_time[0];
   assign chain.full       = cell_valid[CAPACITY-1];
   assign chain.hit        = |match_vec;

   twt_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_task_id       (req_task_id),
      .req_time_value    (req_time_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_taken_id      (rsp_taken_id),
      .rsp_not_empty     (rsp_not_empty),
      .rsp_earliest_time (rsp_earliest_time),
      .chain             (chain),
      .ctrl              (ctrl)
   );

endmodule

### rtl/core/twt_checker.sv
module twt_checker import twt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input logic [ID_BITS-1:0]   rsp_taken_id,
   input logic                 rsp_not_empty,
   input logic [TIME_BITS-1:0] rsp_earliest_time
);

   // stalled response holds its status, taken id and earliest time
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_taken_id) && $stable(rsp_earliest_time))
      else $error("response changed while stalled");

   // one request in flight
   a_one_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is open");

   a_empty_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_not_empty |-> rsp_earliest_time == '0)
      else $error("earliest time non-zero on empty table");

   a_taken_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_taken_id == '0)
      else $error("taken id set on failed request");

   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_DUP) |-> rsp_not_empty)
      else $error("rejected add reports empty table");

endmodule

bind timeout_ordered_wait_table twt_checker u_twt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_taken_id      (rsp_taken_id),
   .rsp_not_empty     (rsp_not_empty),
   .rsp_earliest_time (rsp_earliest_time)
);
